// ----- design/stpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_pkg: shared types and constants for the DDS step pulse generator
// Register map, configuration bundle and the increment record that passes
// from the scaling pipeline to the phase accumulator.
// ----------------------------------------------------------------------------
package stpg_pkg;

	localparam int ACC_W       = 32;
	localparam int FREQ_W      = 31;
	localparam int STEP_BIT_W  = 5;
	localparam int SCALE_W     = 48;
	localparam int SCALE_FRAC  = 16;
	localparam int JOINT_W     = 5;
	localparam int ENABLE_W    = 8;
	localparam int ENABLE_IDX_W = $clog2(ENABLE_W);
	localparam int STEP_BIT_MAX = 30;
	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 5;

	// register indexes, at byte address 8 * index
	typedef enum logic [1:0] {
		REG_MAX_FREQUENCY = 2'd0,
		REG_STEP_BIT      = 2'd1,
		REG_RATE_SCALE    = 2'd2,
		REG_JOINT_INDEX   = 2'd3
	} stpg_reg_t;

	localparam logic [FREQ_W-1:0]     MAX_FREQUENCY_RST = FREQ_W'(1);
	localparam logic [STEP_BIT_W-1:0] STEP_BIT_RST      = '0;
	localparam logic [SCALE_W-1:0]    RATE_SCALE_RST    = '0;
	localparam logic [JOINT_W-1:0]    JOINT_INDEX_RST   = '0;

	typedef struct packed {
		logic [FREQ_W-1:0]     max_frequency;
		logic [STEP_BIT_W-1:0] step_bit;
		logic [SCALE_W-1:0]    rate_scale;
		logic [JOINT_W-1:0]    joint_index;
	} stpg_cfg_t;

	// one scaled request on its way to the accumulator
	typedef struct packed {
		logic             enabled;
		logic             forward;
		logic [ACC_W-1:0] inc;
	} stpg_inc_t;

endpackage

// ----- design/stpg_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_ifs: request channels of the DDS step pulse generator
// Command channel (frequency and enable byte) and feedback channel (step,
// direction, position), both valid/ready.
// ----------------------------------------------------------------------------
interface stpg_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] frequency_command;
	logic [7:0]         enable_bits;

	modport source (output valid, frequency_command, enable_bits, input ready);
	modport sink (input valid, frequency_command, enable_bits, output ready);
endinterface

interface stpg_fb_if;
	logic               valid;
	logic               ready;
	logic               step_pulse;
	logic               direction_level;
	logic signed [31:0] position;

	modport source (output valid, step_pulse, direction_level, position, input ready);
	modport sink (input valid, step_pulse, direction_level, position, output ready);
endinterface

// ----- design/stpg_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_cfg: configuration registers
// APB-style register file, 64-bit data, registers at byte address 8 * index.
// ----------------------------------------------------------------------------
module stpg_cfg
	import stpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output stpg_cfg_t             cfg
);

	stpg_cfg_t cfg_q;
	stpg_reg_t reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_sel = stpg_reg_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// write the selected register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frequency <= MAX_FREQUENCY_RST;
			cfg_q.step_bit      <= STEP_BIT_RST;
			cfg_q.rate_scale    <= RATE_SCALE_RST;
			cfg_q.joint_index   <= JOINT_INDEX_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MAX_FREQUENCY: cfg_q.max_frequency <= pwdata[FREQ_W-1:0];
				REG_STEP_BIT:      cfg_q.step_bit      <= pwdata[STEP_BIT_W-1:0];
				REG_RATE_SCALE:    cfg_q.rate_scale    <= pwdata[SCALE_W-1:0];
				REG_JOINT_INDEX:   cfg_q.joint_index   <= pwdata[JOINT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			REG_MAX_FREQUENCY: prdata = APB_DATA_W'(cfg_q.max_frequency);
			REG_STEP_BIT:      prdata = APB_DATA_W'(cfg_q.step_bit);
			REG_RATE_SCALE:    prdata = APB_DATA_W'(cfg_q.rate_scale);
			REG_JOINT_INDEX:   prdata = APB_DATA_W'(cfg_q.joint_index);
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- design/stpg_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_scale: command clamp and scaling pipeline
// Input register, clamp to the frequency limit, Q32.16 multiply in two
// partial products, then saturation and sign to a phase increment.
// ----------------------------------------------------------------------------
module stpg_scale
	import stpg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  stpg_cfg_t cfg,
	stpg_cmd_if.sink  cmd,
	output logic      inc_valid,
	input  logic      inc_ready,
	output stpg_inc_t inc
);

	localparam int HI_W   = SCALE_W - SCALE_FRAC;
	localparam int PHI_W  = FREQ_W + HI_W;
	localparam int PLO_W  = FREQ_W + SCALE_FRAC;

	// pipeline valids and load enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;

	// stage payloads
	logic signed [ACC_W-1:0] cmd_s1;
	logic [ENABLE_W-1:0]     enb_s1;
	logic                    en_s2, neg_s2;
	logic [FREQ_W-1:0]       mag_s2;
	logic                    en_s3, neg_s3;
	logic [PHI_W-1:0]        phi_s3;
	logic [PLO_W-1:0]        plo_s3;
	stpg_inc_t               inc_s4;

	// combinational
	logic                    cfg_ok, joint_on, en_c, neg_c;
	logic signed [ACC_W-1:0] lim_c, cmd_c, abs_c;
	logic [PHI_W-1:0]        phi_c, sum_c;
	logic [PLO_W-1:0]        plo_c;
	logic [FREQ_W-1:0]       msc_c;
	stpg_inc_t               inc_c;

	assign ld_s4     = !v_s4 || inc_ready;
	assign ld_s3     = !v_s3 || ld_s4;
	assign ld_s2     = !v_s2 || ld_s3;
	assign ld_s1     = !v_s1 || ld_s2;
	assign cmd.ready = ld_s1;
	assign inc_valid = v_s4;
	assign inc       = inc_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= cmd.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
		end
	end

	// enable decode, clamp and absolute value
	always_comb begin
		cfg_ok   = (cfg.max_frequency != '0) &&
		           (cfg.step_bit <= STEP_BIT_W'(STEP_BIT_MAX));
		joint_on = (cfg.joint_index < JOINT_W'(ENABLE_W)) &&
		           enb_s1[cfg.joint_index[ENABLE_IDX_W-1:0]];
		en_c     = cfg_ok && joint_on;
		lim_c    = signed'({1'b0, cfg.max_frequency});
		if (cmd_s1 > lim_c)
			cmd_c = lim_c;
		else if (cmd_s1 < -lim_c)
			cmd_c = -lim_c;
		else
			cmd_c = cmd_s1;
		neg_c = cmd_c[ACC_W-1];
		abs_c = neg_c ? -cmd_c : cmd_c;
	end

	// partial products: integer and fraction parts of the scale
	assign phi_c = mag_s2 * cfg.rate_scale[SCALE_W-1:SCALE_FRAC];
	assign plo_c = mag_s2 * cfg.rate_scale[SCALE_FRAC-1:0];

	// sum, drop the fraction, saturate, apply sign
	always_comb begin
		sum_c = phi_s3 + PHI_W'(plo_s3[PLO_W-1:SCALE_FRAC]);
		if (|sum_c[PHI_W-1:FREQ_W])
			msc_c = '1;
		else
			msc_c = sum_c[FREQ_W-1:0];
		inc_c.enabled = en_s3;
		inc_c.forward = !neg_s3 && (msc_c != '0);
		inc_c.inc     = neg_s3 ? (ACC_W'(0) - ACC_W'(msc_c)) : ACC_W'(msc_c);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cmd_s1 <= cmd.frequency_command;
			enb_s1 <= cmd.enable_bits;
		end
		if (ld_s2) begin
			en_s2  <= en_c;
			neg_s2 <= neg_c;
			mag_s2 <= abs_c[FREQ_W-1:0];
		end
		if (ld_s3) begin
			en_s3  <= en_s2;
			neg_s3 <= neg_s2;
			phi_s3 <= phi_c;
			plo_s3 <= plo_c;
		end
		if (ld_s4) begin
			inc_s4 <= inc_c;
		end
	end

endmodule

// ----- design/stpg_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_accum: phase accumulator, step detect and feedback register
// Adds the increment, watches the selected phase bit for a toggle, and
// updates direction and position on a step.
// ----------------------------------------------------------------------------
module stpg_accum
	import stpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [STEP_BIT_W-1:0] step_bit,
	input  logic                  inc_valid,
	output logic                  inc_ready,
	input  stpg_inc_t             inc,
	stpg_fb_if.source             fb
);

	logic [ACC_W-1:0] acc_q, acc_c;
	logic [ACC_W-1:0] pos_q;
	logic             dir_q;
	logic             step_q;
	logic             fb_valid_q;
	logic             take, pulse_c;

	assign inc_ready = !fb_valid_q || fb.ready;
	assign take      = inc_valid && inc_ready;
	assign acc_c     = acc_q + inc.inc;
	assign pulse_c   = inc.enabled && ((acc_q[step_bit] ^ acc_c[step_bit]) == 1'b1);

	assign fb.valid           = fb_valid_q;
	assign fb.step_pulse      = step_q;
	assign fb.direction_level = dir_q;
	assign fb.position        = signed'(pos_q);

	// advance state and load the feedback register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pos_q      <= '0;
			dir_q      <= 1'b0;
			step_q     <= 1'b0;
			fb_valid_q <= 1'b0;
		end else begin
			if (take) begin
				step_q <= pulse_c;
				if (inc.enabled)
					acc_q <= acc_c;
				if (pulse_c) begin
					dir_q <= inc.forward;
					pos_q <= inc.forward ? pos_q + ACC_W'(1) : pos_q - ACC_W'(1);
				end
			end
			if (inc_ready)
				fb_valid_q <= inc_valid;
		end
	end

	// disabled request raises no step and leaves accumulator, position and direction alone
	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !inc.enabled) |=> (!step_q && $stable(acc_q) && $stable(pos_q) &&
		$stable(dir_q)))
		else $error("disabled request changed state");

	// a step moves position by one in the latched direction
	a_step_moves_one: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pulse_c) |=> (pos_q == (dir_q ? $past(pos_q) + ACC_W'(1) :
		$past(pos_q) - ACC_W'(1))))
		else $error("step did not move position by one");

	// no step means position and direction hold
	a_no_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && pulse_c) |=> ($stable(pos_q) && $stable(dir_q)))
		else $error("position changed without a step");

	// zero increment never steps
	a_zero_inc_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (inc.inc == '0)) |=> !step_q)
		else $error("step on zero increment");

endmodule

// ----- design/dds_step_pulse_generator.sv -----
`timescale 1ns / 1ps
// A command passes the input, clamp, product and increment registers, then
// the feedback register. Throughput: one command per clock while fb.ready
// is high; the 32-bit phase accumulator add and step detect close their loop
// unpipelined; the 31x48 scale multiply runs as two staged partial products.
// Reset (arst_n low): accumulator, position and direction clear to zero,
// registers return to max_frequency 1, step_bit 0, rate_scale 0, joint 0.
// ----------------------------------------------------------------------------
// dds_step_pulse_generator: DDS step pulse generator for one stepper joint
// Scales a clamped frequency command to a phase increment, accumulates it,
// and emits step, direction and position feedback per command.
// ----------------------------------------------------------------------------
module dds_step_pulse_generator
	import stpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	stpg_cmd_if.sink              cmd,
	stpg_fb_if.source             fb
);

	stpg_cfg_t cfg;
	logic      inc_valid, inc_ready;
	stpg_inc_t inc;

	// configuration registers
	stpg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamp and scale
	stpg_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.inc_valid (inc_valid),
		.inc_ready (inc_ready),
		.inc       (inc)
	);

	// accumulate and report
	stpg_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_bit  (cfg.step_bit),
		.inc_valid (inc_valid),
		.inc_ready (inc_ready),
		.inc       (inc),
		.fb        (fb)
	);

endmodule

// ----- verif/dds_step_pulse_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_step_pulse_generator_tb: regression bench for the DDS step generator
// Drives frequency commands with random gaps and configuration writes over
// the register port. A scoreboard predicts step, direction and position for
// every accepted command and checks each feedback request in order.
// ----------------------------------------------------------------------------
module dds_step_pulse_generator_tb;
	import stpg_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CONFIGS_PER_MODE = 6;
	localparam int ITEMS_PER_CONFIG = 88;

	// predicted joint state and queue of expected feedback requests
	class step_scoreboard;
		typedef struct packed {
			logic        step;
			logic        dir;
			logic [31:0] pos;
		} feedback_t;

		stpg_cfg_t   cfg;
		logic [31:0] phase;
		logic [31:0] position;
		logic        dir;
		feedback_t   expected[$];
		int          errors;

		function new();
			cfg = '{max_frequency: MAX_FREQUENCY_RST, step_bit: STEP_BIT_RST,
				rate_scale: RATE_SCALE_RST, joint_index: JOINT_INDEX_RST};
			phase = '0;
			position = '0;
			dir = 1'b0;
			errors = 0;
		endfunction

		function void write_register(stpg_reg_t idx, logic [63:0] value);
			case (idx)
				REG_MAX_FREQUENCY: cfg.max_frequency = value[FREQ_W-1:0];
				REG_STEP_BIT:      cfg.step_bit = value[STEP_BIT_W-1:0];
				REG_RATE_SCALE:    cfg.rate_scale = value[SCALE_W-1:0];
				REG_JOINT_INDEX:   cfg.joint_index = value[JOINT_W-1:0];
				default: ;
			endcase
		endfunction

		// advance the accumulator by one tick if enabled and queue the feedback it yields
		function void note_command(logic signed [31:0] freq, logic [7:0] en);
			logic signed [32:0] lim;
			logic signed [32:0] clamped;
			logic               neg;
			logic [31:0]        mag;
			logic [79:0]        prod;
			logic [31:0]        inc;
			logic [31:0]        prior;
			logic [31:0]        flips;
			logic               pulse;
			pulse = 1'b0;
			if (cfg.max_frequency != '0 && cfg.step_bit <= STEP_BIT_MAX &&
					cfg.joint_index < ENABLE_W &&
					en[cfg.joint_index[ENABLE_IDX_W-1:0]]) begin
				lim = $signed({2'b00, cfg.max_frequency});
				clamped = freq;
				if (clamped > lim)
					clamped = lim;
				else if (clamped < -lim)
					clamped = -lim;
				neg = clamped < 0;
				mag = neg ? 32'(-clamped) : 32'(clamped);
				// exact floor of the Q32.16 product, saturated to 31 bits
				prod = 80'(mag) * 80'(cfg.rate_scale);
				prod = prod >> SCALE_FRAC;
				mag = (prod > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
				inc = neg ? 32'(-mag) : mag;
				prior = phase;
				phase = prior + inc;
				flips = prior ^ phase;
				pulse = flips[cfg.step_bit];
				if (pulse) begin
					dir = !neg && mag != '0;
					position = dir ? position + 32'd1 : position - 32'd1;
				end
			end
			expected.push_back('{step: pulse, dir: dir, pos: position});
		endfunction

		function void check_feedback(logic step, logic dir_level, logic [31:0] pos);
			feedback_t e;
			if (expected.size() == 0) begin
				$error("feedback request with no command pending");
				errors++;
				return;
			end
			e = expected.pop_front();
			if (step !== e.step) begin
				$error("step_pulse: expected %0d, got %0d", e.step, step);
				errors++;
			end
			if (dir_level !== e.dir) begin
				$error("direction_level: expected %0d, got %0d", e.dir, dir_level);
				errors++;
			end
			if (pos !== e.pos) begin
				$error("position: expected %0d, got %0d", $signed(e.pos), $signed(pos));
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	stpg_cmd_if cmd();
	stpg_fb_if  fb();

	step_scoreboard sb = new();

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_left = 0;
	bit start_long_hold = 1'b0;
	int stall_cycles = 0;

	dds_step_pulse_generator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd),
		.fb      (fb)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// feedback side: random back-pressure, or a long hold when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb.ready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			fb.ready <= 1'b0;
			hold_left--;
		end else if (start_long_hold) begin
			start_long_hold = 1'b0;
			hold_left = LONG_HOLD;
			fb.ready <= 1'b0;
		end else begin
			fb.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// observe both channels, check feedback, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				sb.note_command(cmd.frequency_command, cmd.enable_bits);
			if (fb.valid && fb.ready)
				sb.check_feedback(fb.step_pulse, fb.direction_level, fb.position);
			if ((cmd.valid && cmd.ready) || (fb.valid && fb.ready) || psel) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("dds_step_pulse_generator regression: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic [SCALE_W-1:0] nominal_scale(logic [FREQ_W-1:0] maxf,
			logic [STEP_BIT_W-1:0] sbit);
		return SCALE_W'((64'd1 << (sbit + SCALE_FRAC)) / maxf);
	endfunction

	task automatic apb_write(stpg_reg_t idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_register(idx, value);
	endtask

	// offer one request, with a random gap ahead of it
	task automatic send_command(logic signed [31:0] freq, logic [7:0] en);
		if ($urandom_range(99) < src_idle_pct) begin
			cmd.valid <= 1'b0;
			cmd.frequency_command <= $urandom;
			cmd.enable_bits <= $urandom;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		cmd.valid <= 1'b1;
		cmd.frequency_command <= freq;
		cmd.enable_bits <= en;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// drop valid, let the monitor record the last request, then drain
	task automatic wait_for_results();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic configure(logic [FREQ_W-1:0] maxf, logic [STEP_BIT_W-1:0] sbit,
			logic [SCALE_W-1:0] scale, logic [JOINT_W-1:0] joint);
		wait_for_results();
		apb_write(REG_MAX_FREQUENCY, APB_DATA_W'(maxf));
		apb_write(REG_STEP_BIT, APB_DATA_W'(sbit));
		apb_write(REG_RATE_SCALE, APB_DATA_W'(scale));
		apb_write(REG_JOINT_INDEX, APB_DATA_W'(joint));
	endtask

	initial begin
		logic [FREQ_W-1:0]     maxf;
		logic [STEP_BIT_W-1:0] sbit;
		logic [SCALE_W-1:0]    scale;
		logic [JOINT_W-1:0]    joint;
		logic [31:0]           mag;
		logic signed [31:0]    freq;
		logic [7:0]            en;

		cmd.valid = 1'b0;
		cmd.frequency_command = '0;
		cmd.enable_bits = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero scale, so no step can occur
		src_idle_pct = 12;
		sink_idle_pct = 79;
		send_command(32'sd1000, 8'h01);
		send_command(-32'sd5, 8'h01);

		// nominal scale: full rate both ways, clamping, joint disabled
		configure(31'd1000, 5'd4, nominal_scale(31'd1000, 5'd4), 5'd0);
		send_command(32'sd1000, 8'h01);
		send_command(-32'sd1000, 8'h01);
		send_command(32'sh7FFF_FFFF, 8'h01);
		send_command(32'sh8000_0000, 8'h01);
		send_command(32'sd0, 8'h01);
		send_command(32'sd500, 8'hFE);
		send_command(-32'sd1, 8'hFF);
		send_command(32'sd1, 8'hFF);

		// oversized scale saturates the increment, top enable bit
		configure(31'h7FFF_FFFF, 5'd30, '1, 5'd7);
		send_command(32'sh7FFF_FFFF, 8'h80);
		send_command(32'sh8000_0000, 8'h80);
		send_command(32'sd12345, 8'h7F);

		// joint index past the enable byte is never enabled
		configure(31'd1, 5'd0, SCALE_W'(1) << SCALE_FRAC, 5'd8);
		send_command(32'sd1, 8'hFF);
		configure(31'd1, 5'd0, SCALE_W'(1) << SCALE_FRAC, 5'd31);
		send_command(32'sd1, 8'hFF);

		// invalid settings: zero clamp limit, step bit out of range
		configure(31'd0, 5'd0, SCALE_W'(1) << SCALE_FRAC, 5'd0);
		send_command(32'sd5, 8'hFF);
		configure(31'd100, 5'd31, SCALE_W'(1) << SCALE_FRAC, 5'd0);
		send_command(32'sd5, 8'hFF);

		// step bit zero: every unit increment steps
		configure(31'd1, 5'd0, SCALE_W'(1) << SCALE_FRAC, 5'd0);
		send_command(32'sd1, 8'h01);
		send_command(-32'sd1, 8'h01);
		send_command(-32'sd1, 8'h01);

		// random part: three back-pressure modes, several settings each
		for (int mode = 0; mode < 3; mode++) begin
			for (int k = 0; k < CONFIGS_PER_MODE; k++) begin
				case ($urandom_range(3))
					0: maxf = FREQ_W'($urandom_range(1000, 1));
					1: maxf = FREQ_W'($urandom_range(200000, 1000));
					2: maxf = FREQ_W'($urandom_range(32'h7FFF_FFFF, 1));
					default: maxf = '1;
				endcase
				sbit = STEP_BIT_W'($urandom_range(STEP_BIT_MAX, 0));
				case ($urandom_range(9))
					0: scale = SCALE_W'({$urandom, $urandom});
					1: scale = '0;
					2: scale = nominal_scale(maxf, sbit) * SCALE_W'($urandom_range(4, 2));
					default: scale = nominal_scale(maxf, sbit);
				endcase
				joint = ($urandom_range(9) == 0) ? JOINT_W'($urandom_range(31, 8))
					: JOINT_W'($urandom_range(7, 0));
				configure(maxf, sbit, scale, joint);

				case (mode)
					0: begin
						src_idle_pct = 12;
						sink_idle_pct = 79;
					end
					1: begin
						src_idle_pct = 79;
						sink_idle_pct = 12;
					end
					default: begin
						src_idle_pct = 0;
						sink_idle_pct = 0;
					end
				endcase
				// hold the feedback side off while commands keep coming
				if (mode == 2 && k == 0)
					start_long_hold = 1'b1;

				for (int n = 0; n < ITEMS_PER_CONFIG; n++) begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5: begin
							mag = $urandom_range(32'(maxf), 0);
							freq = $urandom_range(1) ? -$signed(mag) : $signed(mag);
						end
						6, 7: freq = $urandom;
						8: begin
							case ($urandom_range(4))
								0: freq = 32'sh7FFF_FFFF;
								1: freq = 32'sh8000_0000;
								2: freq = $signed(32'(maxf));
								3: freq = -$signed(32'(maxf));
								default: freq = '0;
							endcase
						end
						default: freq = $signed(32'($urandom_range(6, 0))) - 32'sd3;
					endcase
					en = $urandom;
					if ($urandom_range(99) < 85 && joint < ENABLE_W)
						en[joint[ENABLE_IDX_W-1:0]] = 1'b1;
					send_command(freq, en);
				end
			end
		end

		// let the pipeline empty, then report
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("dds_step_pulse_generator regression: pass");
		else
			$display("dds_step_pulse_generator regression: fail");
		$finish;
	end

endmodule
